// ===== src/dnsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsp_pkg
// Shared types and constants for the DNS response A-record parser.
// ----------------------------------------------------------------------------
package dnsp_pkg;

  // Bytes of one message that are parsed, length prefix included
  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int BYTE_CNT_W        = $clog2(MAX_MESSAGE_BYTES + 1);

  // Status codes
  localparam logic [2:0] ST_FOUND  = 3'd0;
  localparam logic [2:0] ST_ID     = 3'd1;
  localparam logic [2:0] ST_NOANS  = 3'd2;
  localparam logic [2:0] ST_TRUNC  = 3'd3;
  localparam logic [2:0] ST_NOADDR = 3'd4;

  // Name compression marker bits
  localparam logic [7:0] PTR_MASK = 8'hC0;

  // Configuration register indexes
  localparam logic REG_EXPECTED_ID = 1'b0;
  localparam logic REG_TCP_FRAMING = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dnsp_beat_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic        tcp_framing;
  } dnsp_cfg_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  status;
    logic [31:0] ipv4_address;
  } dnsp_result_t;

endpackage

// ===== src/dnsp_in_stage.sv =====
// ----------------------------------------------------------------------------
// dnsp_in_stage
// Input register for the byte stream; holds a last beat until the result
// register has room.
// ----------------------------------------------------------------------------
module dnsp_in_stage
  import dnsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  input  logic       out_room,
  output logic       beat_fire,
  output dnsp_beat_t beat
);

  logic       valid_r;
  dnsp_beat_t beat_r;

  // a plain byte always moves on; a last byte needs a free result slot
  assign beat_fire = valid_r && (!beat_r.last || out_room);
  assign in_tready = !valid_r || beat_fire;
  assign beat      = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (beat_fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      beat_r.data <= in_tdata;
      beat_r.last <= in_tlast;
    end
  end

endmodule

// ===== src/dnsp_parser.sv =====
// ----------------------------------------------------------------------------
// dnsp_parser
// Per-byte parse state: header, questions, answers; emits one result per
// message on its last byte.
// ----------------------------------------------------------------------------
module dnsp_parser
  import dnsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dnsp_cfg_t    cfg,
  input  logic         beat_fire,
  input  dnsp_beat_t   beat,
  output logic         res_fire,
  output dnsp_result_t res
);

  localparam logic [3:0] PH_START        = 4'd0;
  localparam logic [3:0] PH_PREFIX       = 4'd1;
  localparam logic [3:0] PH_HEADER       = 4'd2;
  localparam logic [3:0] PH_QNAME        = 4'd3;
  localparam logic [3:0] PH_QTAIL        = 4'd4;
  localparam logic [3:0] PH_ANAME_FIRST  = 4'd5;
  localparam logic [3:0] PH_ANAME_PTR    = 4'd6;
  localparam logic [3:0] PH_ANAME_LABELS = 4'd7;
  localparam logic [3:0] PH_AFIXED       = 4'd8;
  localparam logic [3:0] PH_ADATA        = 4'd9;
  localparam logic [3:0] PH_DONE         = 4'd10;

  logic [3:0]            phase_r,   phase_nxt;
  logic [3:0]            idx_r,     idx_nxt;
  logic [15:0]           shift_r,   shift_nxt;
  logic [15:0]           q_left_r,  q_left_nxt;
  logic [15:0]           a_left_r,  a_left_nxt;
  logic [15:0]           rd_left_r, rd_left_nxt;
  logic                  is_addr_r, is_addr_nxt;
  logic [31:0]           addr_r,    addr_nxt;
  logic [2:0]            code_r,    code_nxt;
  logic [BYTE_CNT_W-1:0] cnt_r,     cnt_nxt;

  logic        take;
  logic [7:0]  b;
  logic [15:0] sh;
  logic [15:0] a_dec;
  logic [15:0] q_dec;
  logic [15:0] rd_dec;

  assign b    = beat.data;
  assign take = (cnt_r < BYTE_CNT_W'(MAX_MESSAGE_BYTES));

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    shift_nxt   = shift_r;
    q_left_nxt  = q_left_r;
    a_left_nxt  = a_left_r;
    rd_left_nxt = rd_left_r;
    is_addr_nxt = is_addr_r;
    addr_nxt    = addr_r;
    code_nxt    = code_r;
    cnt_nxt     = cnt_r;
    sh          = 16'd0;
    a_dec       = a_left_r - 16'd1;
    q_dec       = q_left_r - 16'd1;
    rd_dec      = rd_left_r - 16'd1;

    if (take) begin
      cnt_nxt = cnt_r + BYTE_CNT_W'(1);
      if (phase_r != PH_DONE) begin
        // first byte of a message picks the framing
        if (phase_r == PH_START) begin
          phase_nxt = cfg.tcp_framing ? PH_PREFIX : PH_HEADER;
          idx_nxt   = 4'd0;
          shift_nxt = 16'd0;
        end
        sh = {shift_nxt[7:0], b};
        case (phase_nxt)
          PH_PREFIX: begin
            if (idx_nxt == 4'd0) begin
              idx_nxt = 4'd1;
            end else begin
              idx_nxt   = 4'd0;
              shift_nxt = 16'd0;
              phase_nxt = PH_HEADER;
            end
          end
          PH_HEADER: begin
            shift_nxt = sh;
            if (idx_nxt == 4'd1 && sh != cfg.expected_id) begin
              code_nxt  = ST_ID;
              phase_nxt = PH_DONE;
            end else if (idx_nxt == 4'd7 && sh == 16'd0) begin
              a_left_nxt = sh;
              code_nxt   = ST_NOANS;
              phase_nxt  = PH_DONE;
            end else begin
              if (idx_nxt == 4'd5) begin
                q_left_nxt = sh;
              end
              if (idx_nxt == 4'd7) begin
                a_left_nxt = sh;
              end
              if (idx_nxt >= 4'd11) begin
                idx_nxt   = 4'd0;
                phase_nxt = (q_left_nxt != 16'd0) ? PH_QNAME : PH_ANAME_FIRST;
              end else begin
                idx_nxt = idx_nxt + 4'd1;
              end
            end
          end
          PH_QNAME: begin
            if (b == 8'd0) begin
              idx_nxt   = 4'd0;
              phase_nxt = PH_QTAIL;
            end
          end
          PH_QTAIL: begin
            if (idx_nxt >= 4'd3) begin
              idx_nxt    = 4'd0;
              q_left_nxt = q_dec;
              phase_nxt  = (q_dec != 16'd0) ? PH_QNAME : PH_ANAME_FIRST;
            end else begin
              idx_nxt = idx_nxt + 4'd1;
            end
          end
          PH_ANAME_FIRST: begin
            idx_nxt   = 4'd0;
            shift_nxt = 16'd0;
            if ((b & PTR_MASK) != 8'd0) begin
              phase_nxt = PH_ANAME_PTR;
            end else if (b == 8'd0) begin
              phase_nxt = PH_AFIXED;
            end else begin
              phase_nxt = PH_ANAME_LABELS;
            end
          end
          PH_ANAME_PTR: begin
            phase_nxt = PH_AFIXED;
          end
          PH_ANAME_LABELS: begin
            if (b == 8'd0) begin
              phase_nxt = PH_AFIXED;
            end
          end
          PH_AFIXED: begin
            shift_nxt = sh;
            if (idx_nxt == 4'd1) begin
              is_addr_nxt = (sh == 16'd1);
            end
            if (idx_nxt >= 4'd9) begin
              idx_nxt     = 4'd0;
              rd_left_nxt = sh;
              if (sh != 16'd4) begin
                is_addr_nxt = 1'b0;
              end
              addr_nxt = 32'd0;
              if (sh == 16'd0) begin
                a_left_nxt = a_dec;
                if (a_dec == 16'd0) begin
                  code_nxt  = ST_NOADDR;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_ANAME_FIRST;
                end
              end else begin
                phase_nxt = PH_ADATA;
              end
            end else begin
              idx_nxt = idx_nxt + 4'd1;
            end
          end
          PH_ADATA: begin
            if (is_addr_r) begin
              addr_nxt = {addr_r[23:0], b};
            end
            rd_left_nxt = rd_dec;
            if (rd_dec == 16'd0) begin
              if (is_addr_r) begin
                code_nxt  = ST_FOUND;
                phase_nxt = PH_DONE;
              end else begin
                a_left_nxt = a_dec;
                if (a_dec == 16'd0) begin
                  code_nxt  = ST_NOADDR;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_ANAME_FIRST;
                end
              end
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  // result taken from the state after this byte
  assign res_fire         = beat_fire && beat.last;
  assign res.found        = (code_nxt == ST_FOUND);
  assign res.status       = code_nxt;
  assign res.ipv4_address = (code_nxt == ST_FOUND) ? addr_nxt : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      phase_r   <= PH_START;
      idx_r     <= 4'd0;
      shift_r   <= 16'd0;
      q_left_r  <= 16'd0;
      a_left_r  <= 16'd0;
      rd_left_r <= 16'd0;
      is_addr_r <= 1'b0;
      addr_r    <= 32'd0;
      code_r    <= ST_TRUNC;
      cnt_r     <= '0;
    end else if (beat_fire) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      shift_r   <= shift_nxt;
      q_left_r  <= q_left_nxt;
      a_left_r  <= a_left_nxt;
      rd_left_r <= rd_left_nxt;
      is_addr_r <= is_addr_nxt;
      addr_r    <= addr_nxt;
      code_r    <= code_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

// ===== src/dns_response_a_record_parser.sv =====
// ----------------------------------------------------------------------------
// dns_response_a_record_parser
// Byte-stream DNS response parser that extracts the first IPv4 A record.
// ----------------------------------------------------------------------------
// A last byte's result goes through the input register and the result register to out_tvalid.
// Throughput: 1 byte per cycle; the per-byte parse state update sets this.
// A last byte waits in the input register while the result register is full.
// Reset (rst_n low, synchronous): pipeline empty, parse state at message
// start, expected_id 0, tcp_framing 0.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser
  import dnsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] ipv4_address
  output logic [3:0]  out_tuser,   // [0] found, [3:1] status
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dnsp_cfg_t    cfg_r;
  dnsp_beat_t   beat;
  dnsp_result_t res;
  dnsp_result_t out_res_r;
  logic         out_valid_r;
  logic         beat_fire;
  logic         res_fire;
  logic         out_room;
  logic         cfg_wr;
  logic         reg_sel;

  // ---------------- register file ----------------
  // registers at byte address 0 (expected_id) and 4 (tcp_framing)
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id <= 16'd0;
      cfg_r.tcp_framing <= 1'b0;
    end else if (cfg_wr) begin
      if (reg_sel == REG_EXPECTED_ID) begin
        cfg_r.expected_id <= cfg_pwdata[15:0];
      end else begin
        cfg_r.tcp_framing <= cfg_pwdata[0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EXPECTED_ID: cfg_prdata = {16'd0, cfg_r.expected_id};
      REG_TCP_FRAMING: cfg_prdata = {31'd0, cfg_r.tcp_framing};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  // result slot is free if empty or being drained this cycle
  assign out_room = !out_valid_r || out_tready;

  dnsp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_room  (out_room),
    .beat_fire (beat_fire),
    .beat      (beat)
  );

  // ---------------- parse state ----------------
  dnsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .beat_fire (beat_fire),
    .beat      (beat),
    .res_fire  (res_fire),
    .res       (res)
  );

  // ---------------- result register ----------------
  // res_fire only happens when out_room is set, so nothing is overwritten
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.ipv4_address;
  assign out_tuser  = {out_res_r.status, out_res_r.found};

endmodule

// ===== src/dnsp_checker.sv =====
// ----------------------------------------------------------------------------
// dnsp_checker
// Port-level checks for the DNS response A-record parser.
// ----------------------------------------------------------------------------
module dnsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // result channel empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // found flag agrees with status code
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tuser[3:1] == 3'd0)))
    else $error("found and status disagree");

  // address is zero unless found
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0)
    else $error("address set without a found record");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:1] <= 3'd4)
    else $error("status code out of range");

endmodule

bind dns_response_a_record_parser dnsp_checker u_dnsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/tb_dns_response_a_record_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_response_a_record_parser
// Self-checking bench for the DNS response A-record parser. Whole responses
// are built byte by byte (optional length prefix, header, questions, answers
// with compressed, root and label names), then cut short, padded, corrupted
// or replaced by noise. A byte-level predictor follows every accepted beat
// and queues the one result due on each last byte; a checker compares every
// result beat field by field. Runs cover both register settings, random
// source gaps and sink stalls, a long sink hold-off and an oversize message.
// ----------------------------------------------------------------------------
module tb_dns_response_a_record_parser;
  import dnsp_pkg::*;

  localparam int QUIET_LIMIT    = 4000;  // cycles with no beat on either side
  localparam int RX_HOLD_CYCLES = 400;   // long sink hold-off

  // Parse position inside one response
  typedef enum logic [3:0] {
    PS_START, PS_PREFIX, PS_HEADER, PS_QNAME, PS_QTAIL, PS_AN_FIRST,
    PS_AN_PTR, PS_AN_LABELS, PS_AN_FIXED, PS_AN_DATA, PS_DONE
  } parse_state_t;

  // How the stimulus encodes an answer owner name
  typedef enum logic [1:0] {NAME_PTR, NAME_ROOT, NAME_LABELS, NAME_MIXED} name_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dns_response_a_record_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [7:0] data_byte
    .in_tlast    (in_tlast),     // last_byte
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [31:0] ipv4_address
    .out_tuser   (out_tuser),    // [0] found, [3:1] status
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           src_idle_pct = 0;    // chance of a gap before each byte
  int           sink_stall_pct = 0;  // chance of out_tready low per cycle
  logic         hold_rx = 1'b0;      // forces a sink hold-off
  logic [7:0]   msg_bytes[$];        // response being sent
  dnsp_result_t pending_results[$];  // results owed by the block, oldest first

  // Register copies as the block should hold them
  logic [15:0]  cur_id;
  logic         cur_tcp;

  // Parser copy
  parse_state_t prs_phase;
  logic [3:0]   prs_idx;
  logic [15:0]  prs_shift;
  logic [15:0]  prs_qleft;
  logic [15:0]  prs_aleft;
  logic [15:0]  prs_rleft;
  logic         prs_is_addr;
  logic [31:0]  prs_addr;
  logic [2:0]   prs_code;
  int           prs_count;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void rearm_parser();
    prs_phase   = PS_START;
    prs_idx     = '0;
    prs_shift   = '0;
    prs_qleft   = '0;
    prs_aleft   = '0;
    prs_rleft   = '0;
    prs_is_addr = 1'b0;
    prs_addr    = '0;
    prs_code    = ST_TRUNC;
    prs_count   = 0;
  endfunction

  // Outcome is fixed; later bytes of the message no longer matter
  function automatic void settle(input logic [2:0] code);
    prs_code  = code;
    prs_phase = PS_DONE;
  endfunction

  function automatic void close_answer();
    prs_aleft = prs_aleft - 16'd1;
    if (prs_aleft == 16'd0) settle(ST_NOADDR);
    else prs_phase = PS_AN_FIRST;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (prs_phase == PS_START) begin
      // framing mode is latched on the first byte of each message
      prs_phase = cur_tcp ? PS_PREFIX : PS_HEADER;
      prs_idx   = '0;
      prs_shift = '0;
    end
    case (prs_phase)
      PS_PREFIX: begin
        if (prs_idx == 4'd0) begin
          prs_idx = 4'd1;
        end else begin
          prs_idx   = '0;
          prs_shift = '0;
          prs_phase = PS_HEADER;
        end
      end
      PS_HEADER: begin
        prs_shift = {prs_shift[7:0], b};
        if (prs_idx == 4'd1 && prs_shift != cur_id) begin
          settle(ST_ID);
        end else if (prs_idx == 4'd7 && prs_shift == 16'd0) begin
          prs_aleft = '0;
          settle(ST_NOANS);
        end else begin
          if (prs_idx == 4'd5) prs_qleft = prs_shift;
          if (prs_idx == 4'd7) prs_aleft = prs_shift;
          if (prs_idx >= 4'd11) begin
            prs_idx   = '0;
            prs_phase = (prs_qleft != 16'd0) ? PS_QNAME : PS_AN_FIRST;
          end else begin
            prs_idx = prs_idx + 4'd1;
          end
        end
      end
      PS_QNAME: begin
        if (b == 8'd0) begin
          prs_idx   = '0;
          prs_phase = PS_QTAIL;
        end
      end
      PS_QTAIL: begin
        // type and class of the question
        if (prs_idx >= 4'd3) begin
          prs_idx   = '0;
          prs_qleft = prs_qleft - 16'd1;
          prs_phase = (prs_qleft != 16'd0) ? PS_QNAME : PS_AN_FIRST;
        end else begin
          prs_idx = prs_idx + 4'd1;
        end
      end
      PS_AN_FIRST: begin
        prs_idx   = '0;
        prs_shift = '0;
        if ((b & PTR_MASK) != 8'd0) prs_phase = PS_AN_PTR;
        else if (b == 8'd0)         prs_phase = PS_AN_FIXED;
        else                        prs_phase = PS_AN_LABELS;
      end
      PS_AN_PTR: prs_phase = PS_AN_FIXED;
      PS_AN_LABELS: begin
        if (b == 8'd0) prs_phase = PS_AN_FIXED;
      end
      PS_AN_FIXED: begin
        // type(2) class(2) ttl(4) rdlength(2)
        prs_shift = {prs_shift[7:0], b};
        if (prs_idx == 4'd1) prs_is_addr = (prs_shift == 16'd1);
        if (prs_idx >= 4'd9) begin
          prs_idx   = '0;
          prs_rleft = prs_shift;
          if (prs_rleft != 16'd4) prs_is_addr = 1'b0;
          prs_addr = '0;
          if (prs_rleft == 16'd0) close_answer();
          else prs_phase = PS_AN_DATA;
        end else begin
          prs_idx = prs_idx + 4'd1;
        end
      end
      PS_AN_DATA: begin
        if (prs_is_addr) prs_addr = {prs_addr[23:0], b};
        prs_rleft = prs_rleft - 16'd1;
        if (prs_rleft == 16'd0) begin
          if (prs_is_addr) settle(ST_FOUND);
          else close_answer();
        end
      end
      default: prs_phase = PS_DONE;
    endcase
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic last);
    dnsp_result_t r;
    // bytes past the size limit only count for the end marker
    if (prs_count < MAX_MESSAGE_BYTES) begin
      prs_count++;
      if (prs_phase != PS_DONE) parse_byte(b);
    end
    if (last) begin
      r.found        = (prs_code == ST_FOUND);
      r.status       = prs_code;
      r.ipv4_address = r.found ? prs_addr : 32'd0;
      pending_results.insert(pending_results.size(), r);
      rearm_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: input beats feed the predictor, result beats are checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_beat(in_tdata, in_tlast);
  end

  always @(posedge clk) begin
    dnsp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with none pending", out_tdata, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found)
          flag_mismatch("found", 32'(out_tuser[0]), 32'(want.found));
        if (out_tuser[3:1] !== want.status)
          flag_mismatch("status", 32'(out_tuser[3:1]), 32'(want.status));
        if (out_tdata !== want.ipv4_address)
          flag_mismatch("ipv4_address", out_tdata, want.ipv4_address);
      end
    end
  end

  // Sink side: random stalls, or a forced hold-off
  always @(negedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: ends the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout, %0d results still pending", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (entered and left at a falling edge)
  // --------------------------------------------------------------------------
  // Valid stays high after a beat so back-to-back bytes need no re-raise;
  // wait_results_done lowers it whenever the stream stops.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_response();
    foreach (msg_bytes[i]) push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  // Sender pause: stream stopped until every owed result is out, plus the
  // pipeline depth so the block is idle before any register access
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write, then read back one register
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_EXPECTED_ID) ? {16'd0, value[15:0]} : {31'd0, value[0]};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_EXPECTED_ID) cur_id = value[15:0];
    else cur_tcp = value[0];
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) flag_mismatch("register readback", cfg_prdata, want);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] nz8();
    return 8'($urandom_range(1, 255));
  endfunction

  // Adds one byte at the end of the response being built
  function automatic void append_byte(input logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  // Well-formed response into msg_bytes. addr_at picks the answer that is
  // an A record of length 4 (out of range: none); qpad lengthens the first
  // question name.
  function automatic void build_response(input logic [15:0] id, input logic [15:0] qdcount,
                                         input logic [15:0] ancount, input int addr_at,
                                         input name_kind_t kind, input logic [31:0] addr,
                                         input int qpad);
    name_kind_t  k;
    logic [15:0] rtype;
    logic [15:0] rdlen;
    int          len;
    msg_bytes.delete();
    if (cur_tcp) begin
      append_byte(rnd8());
      append_byte(rnd8());
    end
    append_byte(id[15:8]);
    append_byte(id[7:0]);
    repeat (2) append_byte(rnd8());                      // flags
    append_byte(qdcount[15:8]);
    append_byte(qdcount[7:0]);
    append_byte(ancount[15:8]);
    append_byte(ancount[7:0]);
    repeat (4) append_byte(rnd8());                      // ns and ar counts
    for (int q = 0; q < qdcount; q++) begin
      if (q == 0) repeat (qpad) append_byte(nz8());
      repeat ($urandom_range(1, 2)) begin
        len = $urandom_range(1, 8);
        append_byte(8'(len));
        repeat (len) append_byte(nz8());
      end
      append_byte(8'h00);
      repeat (4) append_byte(rnd8());
    end
    for (int a = 0; a < ancount; a++) begin
      k = (kind == NAME_MIXED) ? name_kind_t'($urandom_range(0, 2)) : kind;
      case (k)
        NAME_PTR: begin
          // any of the three nonzero top-bit patterns marks a pointer
          append_byte({2'($urandom_range(1, 3)), 6'($urandom)});
          append_byte(rnd8());
        end
        NAME_ROOT: append_byte(8'h00);
        default: begin
          append_byte(8'($urandom_range(1, 63)));
          repeat ($urandom_range(0, 8)) append_byte(nz8());
          append_byte(8'h00);
        end
      endcase
      if (a == addr_at) begin
        rtype = 16'h0001;
        rdlen = 16'd4;
      end else begin
        case ($urandom_range(0, 3))
          0: begin                                       // A type, wrong length
            rtype = 16'h0001;
            rdlen = 16'($urandom_range(0, 8));
            if (rdlen == 16'd4) rdlen = 16'd5;
          end
          1: begin
            rtype = 16'h001C;
            rdlen = 16'd16;
          end
          2: begin
            rtype = 16'h0005;
            rdlen = 16'($urandom_range(0, 12));
          end
          default: begin
            rtype = 16'($urandom);
            if (rtype == 16'h0001) rtype = 16'h0002;
            rdlen = 16'($urandom_range(0, 12));
          end
        endcase
      end
      append_byte(rtype[15:8]);
      append_byte(rtype[7:0]);
      repeat (6) append_byte(rnd8());                    // class, ttl
      append_byte(rdlen[15:8]);
      append_byte(rdlen[7:0]);
      if (a == addr_at) begin
        append_byte(addr[31:24]);
        append_byte(addr[23:16]);
        append_byte(addr[15:8]);
        append_byte(addr[7:0]);
      end else begin
        repeat (rdlen) append_byte(rnd8());
      end
    end
  endfunction

  // Mostly well-formed responses with random content; the rest cut short,
  // padded, wrong id, no answers or plain noise
  task automatic send_random_response();
    int          roll;
    int          cut;
    logic [15:0] an;
    logic [15:0] qd;
    roll = $urandom_range(0, 99);
    an   = 16'($urandom_range(1, 3));
    qd   = 16'($urandom_range(0, 2));
    if (roll < 80) begin
      build_response(cur_id, qd, an, $urandom_range(0, an), NAME_MIXED, $urandom, 0);
    end else if (roll < 86) begin
      build_response(cur_id ^ 16'($urandom_range(1, 65535)), qd, an, 0, NAME_MIXED,
                     $urandom, 0);
    end else if (roll < 92) begin
      build_response(cur_id, qd, 16'd0, 0, NAME_MIXED, 32'd0, 0);
    end else begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 30)) append_byte(rnd8());
    end
    if (roll >= 60 && roll < 72) begin
      cut = $urandom_range(1, msg_bytes.size() - 1);
      msg_bytes = msg_bytes[0:cut-1];
    end else if (roll >= 72 && roll < 80) begin
      repeat ($urandom_range(1, 8)) append_byte(rnd8());
    end
    send_response();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_header_outcomes();
    write_reg(REG_EXPECTED_ID, 32'h0000_BEEF);
    write_reg(REG_TCP_FRAMING, 32'd0);
    // one byte only: ends undecided
    msg_bytes = '{8'h00};
    send_response();
    // wrong id, message ends on the byte that decides it
    build_response(16'hBEEE, 16'd0, 16'd1, 0, NAME_PTR, 32'd0, 0);
    msg_bytes = msg_bytes[0:1];
    send_response();
    // zero answer count, ends on its low byte
    build_response(16'hBEEF, 16'd1, 16'd0, 0, NAME_PTR, 32'd0, 0);
    msg_bytes = msg_bytes[0:7];
    send_response();
    // compressed owner name, all-ones address
    build_response(16'hBEEF, 16'd0, 16'd1, 0, NAME_PTR, 32'hFFFF_FFFF, 0);
    send_response();
    // root owner name after one question, all-zero address
    build_response(16'hBEEF, 16'd1, 16'd1, 0, NAME_ROOT, 32'd0, 0);
    send_response();
    // label names, two questions, answers run out with no A record
    build_response(16'hBEEF, 16'd2, 16'd2, -1, NAME_LABELS, 32'd0, 0);
    send_response();
    // A record in the last of three answers
    build_response(16'hBEEF, 16'd0, 16'd3, 2, NAME_MIXED, $urandom, 0);
    send_response();
    wait_results_done();
  endtask

  task automatic test_length_prefix();
    write_reg(REG_TCP_FRAMING, 32'd1);
    write_reg(REG_EXPECTED_ID, 32'h0000_0000);
    msg_bytes = '{8'hFF};                                // prefix byte only
    send_response();
    build_response(16'h0000, 16'd1, 16'd2, 1, NAME_MIXED, $urandom, 0);
    send_response();
    build_response(16'h8000, 16'd0, 16'd1, 0, NAME_PTR, 32'd0, 0);
    msg_bytes = msg_bytes[0:3];                          // prefix plus id
    send_response();
    wait_results_done();
    write_reg(REG_EXPECTED_ID, 32'hFFFF_FFFF);
    build_response(16'hFFFF, 16'd1, 16'd2, -1, NAME_MIXED, 32'd0, 0);
    send_response();
    build_response(16'hFFFF, 16'd0, 16'd1, 0, NAME_LABELS, $urandom, 0);
    send_response();
    wait_results_done();
  endtask

  // Message past the size limit: a long question name pushes the answer
  // across the limit, so the message ends undecided
  task automatic test_oversize();
    build_response(cur_id, 16'd1, 16'd1, 0, NAME_PTR, $urandom,
                   $urandom_range(990, 1010));
    send_response();
    wait_results_done();
  endtask

  // Sink held off while short messages keep coming, so results back up and
  // the input stalls; then a single message with a full drain after it
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        hold_rx = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      begin
        repeat (8) begin
          case ($urandom_range(0, 2))
            0: begin
              msg_bytes = '{rnd8()};
            end
            1: begin
              build_response(cur_id ^ 16'h0001, 16'd0, 16'd1, 0, NAME_PTR, 32'd0, 0);
              msg_bytes = msg_bytes[0:$urandom_range(1, 5)];
            end
            default: build_response(cur_id, 16'd0, 16'd1, 0, NAME_PTR, $urandom, 0);
          endcase
          send_response();
        end
      end
    join
    wait_results_done();
    send_random_response();
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input logic [15:0] id, input logic tcp,
                                     input int count);
    write_reg(REG_EXPECTED_ID, {16'd0, id});
    write_reg(REG_TCP_FRAMING, {31'd0, tcp});
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    repeat (count) send_random_response();
    wait_results_done();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_id      = '0;
    cur_tcp     = 1'b0;
    rearm_parser();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_header_outcomes();
    test_length_prefix();
    test_oversize();
    test_backpressure();
    test_random_traffic(0,  0,  16'h0000,          1'b0, 2);
    test_random_traffic(63, 0,  16'hFFFF,          1'b1, 2);
    test_random_traffic(0,  63, 16'($urandom),     1'b0, 2);
    test_random_traffic(25, 25, 16'($urandom),     1'b1, 2);

    wait_results_done();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
